[rtl/core/etok_pkg.sv]
// ----------------------------------------------------------------------------
// etok_pkg
// Shared token word type and kind codes for the expression tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package etok_pkg;

    localparam int KIND_W  = 5;
    localparam int COORD_W = 16;
    localparam int LEN_W   = 6;
    localparam int MANT_W  = 64;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_EOF     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd1;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd3;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd4;
    localparam logic [KIND_W-1:0] KIND_STAR    = 5'd5;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_CARET   = 5'd7;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd8;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd9;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd10;
    localparam logic [KIND_W-1:0] KIND_EQ      = 5'd11;
    localparam logic [KIND_W-1:0] KIND_NE      = 5'd12;
    localparam logic [KIND_W-1:0] KIND_LT      = 5'd13;
    localparam logic [KIND_W-1:0] KIND_LE      = 5'd14;
    localparam logic [KIND_W-1:0] KIND_GT      = 5'd15;
    localparam logic [KIND_W-1:0] KIND_GE      = 5'd16;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd17;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd18;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] first_line;
        logic [COORD_W-1:0] first_column;
        logic [LEN_W-1:0]   text_length;
        logic [MANT_W-1:0]  mantissa;
        logic [LEN_W-1:0]   fraction_digits;
        logic               overflow;
        logic               last;
    } tok_t;

    // words offered to the result queue in one cycle
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

`default_nettype wire

[rtl/core/etok_out_q.sv]
// ----------------------------------------------------------------------------
// etok_out_q
// Small result queue: takes up to two words a cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module etok_out_q
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire etok_pkg::push_t push,
    input  wire etok_pkg::tok_t  wr_first,
    input  wire etok_pkg::tok_t  wr_second,
    output logic               room,
    output logic               out_valid,
    input  wire logic          out_stall,
    output etok_pkg::tok_t     out_word
);

    etok_pkg::tok_t mem [etok_pkg::QUEUE_DEPTH];

    logic [etok_pkg::QPTR_W-1:0] head_reg, head_next;
    logic [etok_pkg::QPTR_W-1:0] tail_reg, tail_next;
    logic [etok_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        pop;
    logic [etok_pkg::QCNT_W-1:0] n_push;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_word  = mem[head_reg];
    // two free slots needed, since one byte may give two words
    assign room      = (count_reg <= etok_pkg::QCNT_W'(etok_pkg::QUEUE_DEPTH - 2));

    always_comb
    begin
        n_push     = etok_pkg::QCNT_W'(push.first) + etok_pkg::QCNT_W'(push.second);
        tail_next  = tail_reg + etok_pkg::QPTR_W'(n_push);
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        count_next = count_reg + n_push - etok_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[tail_reg] <= wr_first;
        end
        if (push.second)
        begin
            mem[tail_reg + 1'b1] <= wr_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/expression_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// expression_tokenizer_core
// Byte-stream tokenizer for arithmetic expressions with line/column tracking.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          word
//  in       sink       in_valid/in_stall  ch (source byte, 0 ends source)
//  out      source     out_valid/out_stall kind, first_line, first_column,
//                                         text_length, mantissa,
//                                         fraction_digits, overflow, last
//
//  one byte is taken per cycle while in_stall is low; its token words are registered into the queue
//  a byte gives at most two words, out drains one word per cycle unless out_stall
//  is high, through a four-word queue
//  in_stall rises while fewer than two queue slots are free
//  reset puts the scanner idle at line 1, column 1 and empties the queue
// ----------------------------------------------------------------------------
`default_nettype none

module expression_tokenizer_core
#(
    parameter int TEXT_BUFFER = 64,
    parameter int COORD_BITS  = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  ch,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       kind,
    output logic [15:0]      first_line,
    output logic [15:0]      first_column,
    output logic [5:0]       text_length,
    output logic [63:0]      mantissa,
    output logic [5:0]       fraction_digits,
    output logic             overflow,
    output logic             last
);

    localparam int KW = $clog2(TEXT_BUFFER);
    localparam logic [KW-1:0] KEEP_MAX = KW'(TEXT_BUFFER - 1);
    localparam int LW = etok_pkg::LEN_W;
    localparam int CW = etok_pkg::COORD_W;
    localparam int MW = etok_pkg::MANT_W;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_NUMBER   = 4'b0010,
        MODE_IDENT    = 4'b0100,
        MODE_OPERATOR = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        PEND_EQ   = 2'd0,
        PEND_BANG = 2'd1,
        PEND_LT   = 2'd2,
        PEND_GT   = 2'd3
    } pend_t;

    mode_t                 mode_reg, mode_next;
    pend_t                 pend_reg, pend_next;
    logic                  seen_point_reg, seen_point_next;
    logic [COORD_BITS-1:0] line_reg, line_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] tok_line_reg, tok_line_next;
    logic [COORD_BITS-1:0] tok_col_reg, tok_col_next;
    logic [KW-1:0]         kept_reg, kept_next;
    logic [MW-1:0]         value_reg, value_next;
    logic [KW-1:0]         point_reg, point_next;
    logic                  sat_reg, sat_next;

    logic                  in_fire;
    logic                  room;
    logic                  is_digit, is_alpha, is_space, is_word;
    logic                  keep;
    logic [3:0]            digit;
    logic [MW+3:0]         scaled;
    logic                  consumed, do_move;
    logic                  a_vld, b_vld;
    etok_pkg::tok_t        res_a, res_b;
    etok_pkg::tok_t        wr_first, wr_second;
    etok_pkg::push_t       push;
    etok_pkg::tok_t        out_word;

    // widened copies so any parameter value maps onto the fixed port widths
    logic [COORD_BITS+CW-1:0] tl_wide, tc_wide, ln_wide, cn_wide;
    logic [KW+LW-1:0]         kept_wide, point_wide;
    logic [CW-1:0]            tok_line_o, tok_col_o, line_o, col_o;
    logic [LW-1:0]            kept_o, point_o;

    assign in_stall = !room;
    assign in_fire  = in_valid && !in_stall;

    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    assign is_space = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    assign is_word  = is_alpha || is_digit || (ch == CH_UNDER);
    assign keep     = (kept_reg < KEEP_MAX);
    assign digit    = ch[3:0];
    // value * 10 + digit, with four guard bits for the saturation test
    assign scaled   = {value_reg, 3'b000} + {2'b00, value_reg, 1'b0}
                      + (MW+4)'(digit);

    assign tl_wide    = {{CW{1'b0}}, tok_line_reg};
    assign tc_wide    = {{CW{1'b0}}, tok_col_reg};
    assign ln_wide    = {{CW{1'b0}}, line_reg};
    assign cn_wide    = {{CW{1'b0}}, col_reg};
    assign kept_wide  = {{LW{1'b0}}, kept_reg};
    assign point_wide = {{LW{1'b0}}, point_reg};
    assign tok_line_o = tl_wide[CW-1:0];
    assign tok_col_o  = tc_wide[CW-1:0];
    assign line_o     = ln_wide[CW-1:0];
    assign col_o      = cn_wide[CW-1:0];
    assign kept_o     = kept_wide[LW-1:0];
    assign point_o    = point_wide[LW-1:0];

    always_comb
    begin
        mode_next       = mode_reg;
        pend_next       = pend_reg;
        seen_point_next = seen_point_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        tok_line_next   = tok_line_reg;
        tok_col_next    = tok_col_reg;
        kept_next       = kept_reg;
        value_next      = value_reg;
        point_next      = point_reg;
        sat_next        = sat_reg;
        consumed        = 1'b0;
        do_move         = 1'b0;
        a_vld           = 1'b0;
        b_vld           = 1'b0;
        res_a           = '0;
        res_b           = '0;
        res_a.first_line   = tok_line_o;
        res_a.first_column = tok_col_o;

        if (in_fire)
        begin
            // first: extend or close the token in progress
            case (mode_reg)
                MODE_NUMBER:
                begin
                    if (is_digit || ((ch == CH_DOT) && !seen_point_reg))
                    begin
                        consumed = 1'b1;
                        do_move  = 1'b1;
                        if (ch == CH_DOT)
                        begin
                            seen_point_next = 1'b1;
                        end
                        else if (keep)
                        begin
                            if (!sat_reg)
                            begin
                                if (|scaled[MW+3:MW])
                                begin
                                    value_next = '1;
                                    sat_next   = 1'b1;
                                end
                                else
                                begin
                                    value_next = scaled[MW-1:0];
                                end
                            end
                            if (seen_point_reg)
                            begin
                                point_next = point_reg + 1'b1;
                            end
                        end
                        if (keep)
                        begin
                            kept_next = kept_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        a_vld                 = 1'b1;
                        res_a.kind            = etok_pkg::KIND_NUMBER;
                        res_a.text_length     = kept_o;
                        res_a.mantissa        = value_reg;
                        res_a.fraction_digits = point_o;
                        res_a.overflow        = sat_reg;
                        mode_next             = MODE_IDLE;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_word)
                    begin
                        consumed = 1'b1;
                        do_move  = 1'b1;
                        if (keep)
                        begin
                            kept_next = kept_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        a_vld             = 1'b1;
                        res_a.kind        = etok_pkg::KIND_IDENT;
                        res_a.text_length = kept_o;
                        mode_next         = MODE_IDLE;
                    end
                end
                MODE_OPERATOR:
                begin
                    a_vld     = 1'b1;
                    mode_next = MODE_IDLE;
                    if (ch == CH_EQ)
                    begin
                        consumed          = 1'b1;
                        do_move           = 1'b1;
                        res_a.text_length = LW'(2);
                        case (pend_reg)
                            PEND_EQ:   res_a.kind = etok_pkg::KIND_EQ;
                            PEND_BANG: res_a.kind = etok_pkg::KIND_NE;
                            PEND_LT:   res_a.kind = etok_pkg::KIND_LE;
                            PEND_GT:   res_a.kind = etok_pkg::KIND_GE;
                            default:   res_a.kind = etok_pkg::KIND_EQ;
                        endcase
                    end
                    else
                    begin
                        res_a.text_length = LW'(1);
                        case (pend_reg)
                            PEND_EQ:   res_a.kind = etok_pkg::KIND_ASSIGN;
                            PEND_BANG: res_a.kind = etok_pkg::KIND_UNKNOWN;
                            PEND_LT:   res_a.kind = etok_pkg::KIND_LT;
                            PEND_GT:   res_a.kind = etok_pkg::KIND_GT;
                            default:   res_a.kind = etok_pkg::KIND_ASSIGN;
                        endcase
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            // then: a byte not taken by the old token is handled from idle
            if (!consumed)
            begin
                res_b.first_line   = line_o;
                res_b.first_column = col_o;
                if (ch == CH_NUL)
                begin
                    b_vld      = 1'b1;
                    res_b.kind = etok_pkg::KIND_EOF;
                    line_next  = COORD_BITS'(1);
                    col_next   = COORD_BITS'(1);
                end
                else if (is_space)
                begin
                    do_move = 1'b1;
                end
                else
                begin
                    do_move       = 1'b1;
                    tok_line_next = line_reg;
                    tok_col_next  = col_reg;
                    if (is_digit)
                    begin
                        mode_next       = MODE_NUMBER;
                        kept_next       = KW'(1);
                        value_next      = MW'(digit);
                        point_next      = '0;
                        seen_point_next = 1'b0;
                        sat_next        = 1'b0;
                    end
                    else if (is_alpha || (ch == CH_UNDER))
                    begin
                        mode_next = MODE_IDENT;
                        kept_next = KW'(1);
                    end
                    else if (ch == CH_EQ)
                    begin
                        mode_next = MODE_OPERATOR;
                        pend_next = PEND_EQ;
                    end
                    else if (ch == CH_BANG)
                    begin
                        mode_next = MODE_OPERATOR;
                        pend_next = PEND_BANG;
                    end
                    else if (ch == CH_LT)
                    begin
                        mode_next = MODE_OPERATOR;
                        pend_next = PEND_LT;
                    end
                    else if (ch == CH_GT)
                    begin
                        mode_next = MODE_OPERATOR;
                        pend_next = PEND_GT;
                    end
                    else
                    begin
                        b_vld             = 1'b1;
                        res_b.text_length = LW'(1);
                        case (ch)
                            CH_PLUS:   res_b.kind = etok_pkg::KIND_PLUS;
                            CH_MINUS:  res_b.kind = etok_pkg::KIND_MINUS;
                            CH_STAR:   res_b.kind = etok_pkg::KIND_STAR;
                            CH_SLASH:  res_b.kind = etok_pkg::KIND_SLASH;
                            CH_CARET:  res_b.kind = etok_pkg::KIND_CARET;
                            CH_LPAREN: res_b.kind = etok_pkg::KIND_LPAREN;
                            CH_RPAREN: res_b.kind = etok_pkg::KIND_RPAREN;
                            CH_COMMA:  res_b.kind = etok_pkg::KIND_COMMA;
                            default:   res_b.kind = etok_pkg::KIND_UNKNOWN;
                        endcase
                    end
                end
            end

            // position moves once per byte other than the end byte, saturating
            if (do_move)
            begin
                if (ch == CH_LF)
                begin
                    if (!(&line_reg))
                    begin
                        line_next = line_reg + 1'b1;
                    end
                    col_next = COORD_BITS'(1);
                end
                else if (!(&col_reg))
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end

        if (b_vld)
        begin
            res_b.last = 1'b1;
        end
        else
        begin
            res_a.last = 1'b1;
        end

        push.first  = a_vld || b_vld;
        push.second = a_vld && b_vld;
        wr_first    = a_vld ? res_a : res_b;
        wr_second   = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            pend_reg       <= PEND_EQ;
            seen_point_reg <= 1'b0;
            line_reg       <= COORD_BITS'(1);
            col_reg        <= COORD_BITS'(1);
            tok_line_reg   <= COORD_BITS'(1);
            tok_col_reg    <= COORD_BITS'(1);
            kept_reg       <= '0;
            value_reg      <= '0;
            point_reg      <= '0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            pend_reg       <= pend_next;
            seen_point_reg <= seen_point_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            tok_line_reg   <= tok_line_next;
            tok_col_reg    <= tok_col_next;
            kept_reg       <= kept_next;
            value_reg      <= value_next;
            point_reg      <= point_next;
            sat_reg        <= sat_next;
        end
    end

    etok_out_q u_out_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_first  (wr_first),
        .wr_second (wr_second),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign kind            = out_word.kind;
    assign first_line      = out_word.first_line;
    assign first_column    = out_word.first_column;
    assign text_length     = out_word.text_length;
    assign mantissa        = out_word.mantissa;
    assign fraction_digits = out_word.fraction_digits;
    assign overflow        = out_word.overflow;
    assign last            = out_word.last;

endmodule

`default_nettype wire

[verif/token_stream_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_stream_monitor
// Follows every source byte taken by the tokenizer, works out the token
// words that byte must give, and compares each word leaving the block,
// field by field, against the oldest word still owed.
// ----------------------------------------------------------------------------
module token_stream_monitor
    import etok_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [COORD_W-1:0] first_line,
    input  logic [COORD_W-1:0] first_column,
    input  logic [LEN_W-1:0]   text_length,
    input  logic [MANT_W-1:0]  mantissa,
    input  logic [LEN_W-1:0]   fraction_digits,
    input  logic               overflow,
    input  logic               last,
    output int                 failures,
    output int                 words_checked,
    output int                 words_waiting
);

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_OPERATOR} scan_mode_t;
    typedef enum logic [1:0] {HELD_ASSIGN, HELD_BANG, HELD_LESS, HELD_GREATER} held_op_t;

    localparam logic [COORD_W-1:0] COORD_TOP     = '1;
    localparam logic [COORD_W-1:0] COORD_ONE     = COORD_W'(1);
    localparam logic [MANT_W-1:0]  MANT_TOP      = '1;
    localparam logic [LEN_W-1:0]   KEEP_TOP      = 6'd63;
    localparam logic [7:0]         CH_EOS        = 8'h00;
    localparam logic [7:0]         CH_LF         = 8'h0A;
    localparam logic [7:0]         CH_POINT      = ".";
    localparam logic [7:0]         CH_UNDERSCORE = "_";
    localparam logic [7:0]         CH_EQUALS     = "=";
    localparam int                 REPORT_CAP    = 12;

    scan_mode_t         scan_mode;
    held_op_t           held_op;
    logic               point_seen;
    logic [COORD_W-1:0] cur_line;
    logic [COORD_W-1:0] cur_col;
    logic [COORD_W-1:0] tok_line;
    logic [COORD_W-1:0] tok_col;
    logic [LEN_W-1:0]   kept_len;
    logic [LEN_W-1:0]   frac_count;
    logic [MANT_W-1:0]  digit_acc;
    logic               acc_saturated;

    tok_t expected_words[$];
    tok_t byte_words[$];
    tok_t oldest;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [KIND_W-1:0] lone_kind(held_op_t op);
        case (op)
            HELD_ASSIGN: return KIND_ASSIGN;
            HELD_BANG:   return KIND_UNKNOWN;
            HELD_LESS:   return KIND_LT;
            default:     return KIND_GT;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(held_op_t op);
        case (op)
            HELD_ASSIGN: return KIND_EQ;
            HELD_BANG:   return KIND_NE;
            HELD_LESS:   return KIND_LE;
            default:     return KIND_GE;
        endcase
    endfunction

    function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (got === want)
            return 0;
        if (failures < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    task automatic advance(logic [7:0] c);
        if (c == CH_LF) begin
            if (cur_line != COORD_TOP)
                cur_line++;
            cur_col = COORD_ONE;
        end
        else if (cur_col != COORD_TOP) begin
            cur_col++;
        end
    endtask

    task automatic push_word(logic [KIND_W-1:0] k, logic [LEN_W-1:0] len,
                             logic [MANT_W-1:0] mant, logic [LEN_W-1:0] frac,
                             logic ovf, logic [COORD_W-1:0] ln, logic [COORD_W-1:0] col);
        tok_t w;
        w.kind            = k;
        w.first_line      = ln;
        w.first_column    = col;
        w.text_length     = len;
        w.mantissa        = mant;
        w.fraction_digits = frac;
        w.overflow        = ovf;
        w.last            = 1'b0;
        byte_words.push_back(w);
    endtask

    task automatic add_digit(logic [7:0] c);
        logic [MANT_W-1:0] d;
        d = '0;
        d[3:0] = c[3:0];
        if (!acc_saturated) begin
            if (digit_acc > (MANT_TOP - d) / 64'd10) begin
                digit_acc     = MANT_TOP;
                acc_saturated = 1'b1;
            end
            else begin
                digit_acc = digit_acc * 64'd10 + d;
            end
        end
    endtask

    // sends whatever token is being collected
    task automatic flush_token();
        case (scan_mode)
            SCAN_NUMBER:
                push_word(KIND_NUMBER, kept_len, digit_acc, frac_count, acc_saturated,
                          tok_line, tok_col);
            SCAN_IDENT:
                push_word(KIND_IDENT, kept_len, '0, '0, 1'b0, tok_line, tok_col);
            SCAN_OPERATOR:
                push_word(lone_kind(held_op), 6'd1, '0, '0, 1'b0, tok_line, tok_col);
            default: ;
        endcase
        scan_mode = SCAN_IDLE;
    endtask

    task automatic begin_token(logic [7:0] c);
        if (c == CH_EOS) begin
            push_word(KIND_EOF, '0, '0, '0, 1'b0, cur_line, cur_col);
            cur_line = COORD_ONE;
            cur_col  = COORD_ONE;
        end
        else if (is_space(c)) begin
            advance(c);
        end
        else begin
            tok_line = cur_line;
            tok_col  = cur_col;
            advance(c);
            if (is_digit(c)) begin
                scan_mode      = SCAN_NUMBER;
                kept_len       = 6'd1;
                digit_acc      = '0;
                digit_acc[3:0] = c[3:0];
                frac_count     = '0;
                point_seen     = 1'b0;
                acc_saturated  = 1'b0;
            end
            else if (is_alpha(c) || c == CH_UNDERSCORE) begin
                scan_mode = SCAN_IDENT;
                kept_len  = 6'd1;
            end
            else begin
                case (c)
                    "=": begin held_op = HELD_ASSIGN;  scan_mode = SCAN_OPERATOR; end
                    "!": begin held_op = HELD_BANG;    scan_mode = SCAN_OPERATOR; end
                    "<": begin held_op = HELD_LESS;    scan_mode = SCAN_OPERATOR; end
                    ">": begin held_op = HELD_GREATER; scan_mode = SCAN_OPERATOR; end
                    "+": push_word(KIND_PLUS, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                    "-": push_word(KIND_MINUS, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                    "*": push_word(KIND_STAR, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                    "/": push_word(KIND_SLASH, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                    "^": push_word(KIND_CARET, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                    "(": push_word(KIND_LPAREN, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                    ")": push_word(KIND_RPAREN, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                    ",": push_word(KIND_COMMA, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                    default: push_word(KIND_UNKNOWN, 6'd1, '0, '0, 1'b0, tok_line, tok_col);
                endcase
            end
        end
    endtask

    task automatic predict_byte(logic [7:0] c);
        logic taken;
        taken = 1'b0;
        byte_words.delete();
        case (scan_mode)
            SCAN_NUMBER:
                if (is_digit(c) || (c == CH_POINT && !point_seen)) begin
                    // digits past the text buffer are consumed but not counted
                    if (c == CH_POINT) begin
                        point_seen = 1'b1;
                    end
                    else if (kept_len < KEEP_TOP) begin
                        add_digit(c);
                        if (point_seen)
                            frac_count++;
                    end
                    if (kept_len < KEEP_TOP)
                        kept_len++;
                    advance(c);
                    taken = 1'b1;
                end
                else begin
                    flush_token();
                end
            SCAN_IDENT:
                if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                    if (kept_len < KEEP_TOP)
                        kept_len++;
                    advance(c);
                    taken = 1'b1;
                end
                else begin
                    flush_token();
                end
            SCAN_OPERATOR:
                if (c == CH_EQUALS) begin
                    push_word(pair_kind(held_op), 6'd2, '0, '0, 1'b0, tok_line, tok_col);
                    advance(c);
                    scan_mode = SCAN_IDLE;
                    taken     = 1'b1;
                end
                else begin
                    flush_token();
                end
            default:
                scan_mode = SCAN_IDLE;
        endcase
        if (!taken)
            begin_token(c);
        if (byte_words.size() > 0)
            byte_words[byte_words.size() - 1].last = 1'b1;
        foreach (byte_words[i])
            expected_words.push_back(byte_words[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scan_mode     = SCAN_IDLE;
            held_op       = HELD_ASSIGN;
            point_seen    = 1'b0;
            cur_line      = COORD_ONE;
            cur_col       = COORD_ONE;
            tok_line      = COORD_ONE;
            tok_col       = COORD_ONE;
            kept_len      = '0;
            frac_count    = '0;
            digit_acc     = '0;
            acc_saturated = 1'b0;
            expected_words.delete();
            failures      = 0;
            words_checked = 0;
            words_waiting = 0;
        end
        else begin
            if (in_valid && !in_stall)
                predict_byte(ch);
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    if (failures < REPORT_CAP)
                        $display("%0t: word with no expectation, expected none, got kind %0d",
                                 $time, kind);
                    failures++;
                end
                else begin
                    oldest = expected_words.pop_front();
                    if (field_differs("kind", 64'(oldest.kind), 64'(kind))
                        + field_differs("first_line", 64'(oldest.first_line),
                                        64'(first_line))
                        + field_differs("first_column", 64'(oldest.first_column),
                                        64'(first_column))
                        + field_differs("text_length", 64'(oldest.text_length),
                                        64'(text_length))
                        + field_differs("mantissa", oldest.mantissa, mantissa)
                        + field_differs("fraction_digits", 64'(oldest.fraction_digits),
                                        64'(fraction_digits))
                        + field_differs("overflow", 64'(oldest.overflow), 64'(overflow))
                        + field_differs("last", 64'(oldest.last), 64'(last)) != 0)
                        failures++;
                end
                words_checked++;
            end
            words_waiting = expected_words.size();
        end
    end

endmodule

[verif/expression_tokenizer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_tokenizer_core_test
// Feeds the tokenizer a short hand-made source, then random sources of
// numbers, names, operators, whitespace and stray bytes under changing idle
// and stall patterns; token words are checked by token_stream_monitor.
// ----------------------------------------------------------------------------
module expression_tokenizer_core_test;
    import etok_pkg::*;

    localparam int     HALF_PERIOD     = 6;
    localparam int     RESET_CYCLES    = 4;
    localparam int     PHASE_BYTES     = 350;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     DRAIN_CYCLES    = 20;
    localparam longint RUN_LIMIT_NS    = 12_000_000;
    localparam logic [7:0] CH_EOS      = 8'h00;
    localparam logic [7:0] CH_LF       = 8'h0A;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         ch;
    logic               out_valid;
    logic               out_stall;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] first_line;
    logic [COORD_W-1:0] first_column;
    logic [LEN_W-1:0]   text_length;
    logic [MANT_W-1:0]  mantissa;
    logic [LEN_W-1:0]   fraction_digits;
    logic               overflow;
    logic               last;

    int   failures;
    int   words_checked;
    int   words_waiting;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic hold_off_request   = 1'b0;
    int   bytes_sent         = 0;
    int   sources_sent       = 0;

    logic [7:0] source_bytes[$];
    string      single_ops = "+-*/^(),=!<>.";
    string      pair_heads = "=!<>";
    string      gap_chars  = " \t\n\013\014\015";

    always #HALF_PERIOD clk = ~clk;

    expression_tokenizer_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .ch              (ch),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .first_line      (first_line),
        .first_column    (first_column),
        .text_length     (text_length),
        .mantissa        (mantissa),
        .fraction_digits (fraction_digits),
        .overflow        (overflow),
        .last            (last)
    );

    token_stream_monitor watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .ch              (ch),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .first_line      (first_line),
        .first_column    (first_column),
        .text_length     (text_length),
        .mantissa        (mantissa),
        .fraction_digits (fraction_digits),
        .overflow        (overflow),
        .last            (last),
        .failures        (failures),
        .words_checked   (words_checked),
        .words_waiting   (words_waiting)
    );

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_name_char(logic allow_digit);
        case ($urandom_range(allow_digit ? 7 : 5))
            0, 1, 2: return 8'("a" + $urandom_range(25));
            3, 4:    return 8'("A" + $urandom_range(25));
            5:       return "_";
            default: return rand_digit();
        endcase
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        ch       <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // one source: tokens with random content, mostly well formed, some stray bytes
    task automatic build_source();
        int tokens;
        int n;
        source_bytes.delete();
        tokens = $urandom_range(1, 24);
        repeat (tokens) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: begin
                    n = $urandom_range(1, 6);
                    case ($urandom_range(15))
                        0:       n = $urandom_range(19, 24);
                        1:       n = $urandom_range(60, 75);
                        default: ;
                    endcase
                    repeat (n) source_bytes.push_back(rand_digit());
                    if ($urandom_range(2) == 0) begin
                        source_bytes.push_back(".");
                        repeat ($urandom_range(0, 4)) source_bytes.push_back(rand_digit());
                        if ($urandom_range(7) == 0)
                            source_bytes.push_back(".");
                    end
                end
                6, 7, 8, 9, 10: begin
                    n = ($urandom_range(24) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 8);
                    source_bytes.push_back(rand_name_char(1'b0));
                    repeat (n) source_bytes.push_back(rand_name_char(1'b1));
                end
                11, 12, 13, 14, 15, 16, 17: begin
                    if ($urandom_range(3) == 0) begin
                        source_bytes.push_back(pair_heads[$urandom_range(3)]);
                        source_bytes.push_back("=");
                    end
                    else begin
                        source_bytes.push_back(single_ops[$urandom_range(single_ops.len() - 1)]);
                    end
                end
                default:
                    source_bytes.push_back(8'($urandom_range(1, 255)));
            endcase
            // often no gap, so that tokens butt against each other
            n = ($urandom_range(99) < 45) ? 0 : $urandom_range(1, 3);
            repeat (n) source_bytes.push_back(gap_chars[$urandom_range(gap_chars.len() - 1)]);
        end
        source_bytes.push_back(CH_EOS);
    endtask

    task automatic run_random_sources(int budget);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < budget) begin
            build_source();
            foreach (source_bytes[i])
                send_byte(source_bytes[i]);
            sources_sent++;
        end
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        ch       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // held comparisons, second point, lone bang, two words from one byte
        send_text("a_9==3.5.1!b<=>");
        send_byte(8'hFF);
        send_byte(CH_LF);
        send_byte("=");
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(CH_EOS);

        run_random_sources(PHASE_BYTES);
        sender_idle_pct = 69;
        run_random_sources(PHASE_BYTES);
        sender_idle_pct    = 0;
        receiver_stall_pct = 69;
        hold_off_request   = 1'b1;
        run_random_sources(PHASE_BYTES);
        sender_idle_pct    = 17;
        receiver_stall_pct = 17;
        run_random_sources(PHASE_BYTES);

        in_valid <= 1'b0;
        receiver_stall_pct = 0;
        while (words_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run: %0d source bytes over %0d random sources, %0d token words compared",
                 bytes_sent, sources_sent, words_checked);
        $display("run: long tokens, overflowed numbers, held comparisons, long output hold-off");
        if (failures == 0 && words_waiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
